### hdl/petbl_pkg.sv
// Shared types and constants for the per-entry token bucket limiter.
`timescale 1ns / 1ps

package petbl_pkg;

  localparam int INDEX_W   = 10;
  localparam int TOKEN_W   = 16;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic FUNC_INIT  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_PER_SECOND = 1'b1;

  localparam logic [TOKEN_W-1:0] CAPACITY_RESET = 16'd100;
  localparam logic [TOKEN_W-1:0] REFILL_RESET   = 16'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic               big;
    logic               nonzero;
    logic [TOKEN_W-1:0] quotient;
  } refill_t;

endpackage

### hdl/petbl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module petbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/petbl_slot.sv
// Maps an entry index onto a table slot, taking the index modulo the table depth.
`timescale 1ns / 1ps

module petbl_slot import petbl_pkg::*; #(
  parameter int ENTRIES = 1024,
  parameter int AW      = 10
) (
  input  logic               clk,
  input  logic               load,
  input  logic [INDEX_W-1:0] index,
  output logic [AW-1:0]      slot
);

  if (ENTRIES >= (1 << INDEX_W)) begin : g_direct
    // Every index already names a slot of its own.
    logic [INDEX_W-1:0] index_q;

    always_ff @(posedge clk) begin
      if (load) begin
        index_q <= index;
      end
    end

    assign slot = AW'(index_q);
  end else begin : g_mod
    // The quotient comes from a multiply by a rounded-up reciprocal, which is exact
    // for every index value; the remainder follows from one multiply-back.
    localparam int L  = $clog2(ENTRIES);
    localparam int SH = INDEX_W + L;
    localparam int MW = INDEX_W + 1;
    localparam int PW = INDEX_W + MW;
    localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
    localparam logic [INDEX_W-1:0] DEPTH_K = INDEX_W'(ENTRIES);

    logic [INDEX_W-1:0] index_q;
    logic [INDEX_W-1:0] quot_q;
    logic [PW-1:0]      scaled;
    logic [INDEX_W-1:0] back;
    logic [INDEX_W-1:0] rem;

    assign scaled = PW'(index) * PW'(RECIP);

    always_ff @(posedge clk) begin
      if (load) begin
        index_q <= index;
        quot_q  <= INDEX_W'(scaled >> SH);
      end
    end

    assign back = INDEX_W'(quot_q * DEPTH_K);
    assign rem  = index_q - back;
    assign slot = AW'(rem);
  end

endmodule

### hdl/petbl_refill.sv
// Two-stage refill arithmetic: elapsed ticks times rate, then division by the tick rate.
`timescale 1ns / 1ps

module petbl_refill import petbl_pkg::*; #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic [STAMP_W-1:0] elapsed,
  input  logic [TOKEN_W-1:0] rate,
  output refill_t            refill
);

  // Only quotients below 2^TOKEN_W matter; anything larger fills the bucket anyway.
  // Below that bound the product fits N bits, and a rounded-up reciprocal of
  // N+1 bits gives the exact truncated quotient.
  localparam int L  = $clog2(TICKS_PER_SECOND);
  localparam int N  = TOKEN_W + L;
  localparam int S  = N + L;
  localparam int MW = N + 1;
  localparam int PW = STAMP_W + TOKEN_W;
  localparam int QW = N + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << S) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));
  localparam logic [PW-1:0] NZ_LIMIT  = PW'(TICKS_PER_SECOND);
  localparam logic [PW-1:0] BIG_LIMIT = PW'(TICKS_PER_SECOND) << TOKEN_W;

  logic [PW-1:0] prod;
  logic [QW-1:0] scaled;

  always_ff @(posedge clk) begin
    prod <= PW'(elapsed) * PW'(rate);
  end

  assign scaled = QW'(prod[N-1:0]) * QW'(RECIP);

  always_ff @(posedge clk) begin
    refill.big      <= (prod >= BIG_LIMIT);
    refill.nonzero  <= (prod >= NZ_LIMIT);
    refill.quotient <= TOKEN_W'(scaled >> S);
  end

endmodule

### hdl/per_entry_token_bucket_limiter_unit.sv
// Top level of the per-entry token bucket limiter: control sequencer and bucket memories.
`timescale 1ns / 1ps

// A table of token buckets, one per entry. Each request on the input channel
// (in_valid, in_stall) carries func, entry_index and now_ticks. An init request
// fills the addressed bucket to bucket_capacity and stamps it; a check request
// refills the bucket from the ticks elapsed since its stamp and takes one token
// when any remain. Every request yields exactly one result request on the
// output channel (out_valid, out_stall) with accept set or cleared.
// The bucket state lives in two synchronous RAMs, token counts and refill
// stamps, read and written back by a five-state sequencer; one request is in
// the sequencer at a time, so no two accesses to an entry ever overlap.
// A check passes in order through the slot arithmetic, the RAM read, and the
// refill multiply and divide, before the update state writes the bucket back
// and loads the result; an init writes its bucket and loads its result from
// the address state.
// The finished result sits in an output register, so a new request is taken
// while an earlier result still waits. If the receiver stalls and a second
// result is ready, the sequencer holds it in its last state until the output
// register frees up. Reset clears the sequencer and output valid and restores
// both configuration registers; the memories are not cleared, and an entry
// must be initialized before it is checked.

module per_entry_token_bucket_limiter_unit import petbl_pkg::*; #(
  parameter int ENTRIES          = 1024,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [STAMP_W-1:0]   now_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 accept,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state;
  state_t state_next;

  logic               func_reg;
  logic [STAMP_W-1:0] now_reg;
  logic [TOKEN_W-1:0] bucket_capacity;
  logic [TOKEN_W-1:0] refill_per_second;

  logic               in_take;
  logic               out_free;
  logic               out_load;
  logic               result;

  logic [AW-1:0]      slot;
  logic               rd_en;
  logic               count_we;
  logic               stamp_we;
  logic [TOKEN_W-1:0] count_wdata;
  logic [TOKEN_W-1:0] count_rdata;
  logic [STAMP_W-1:0] stamp_rdata;
  logic [STAMP_W-1:0] elapsed;
  refill_t            refill;

  logic [TOKEN_W:0]   sum;
  logic [TOKEN_W-1:0] capped;
  logic [TOKEN_W-1:0] tokens;
  logic               has_token;
  logic [TOKEN_W-1:0] tokens_left;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity   <= CAPACITY_RESET;
      refill_per_second <= REFILL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BUCKET_CAPACITY:   bucket_capacity   <= cfg_data;
        REG_REFILL_PER_SECOND: refill_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // The request fields are held for the whole time the request is in flight.
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_reg <= func;
      now_reg  <= now_ticks;
    end
  end

  petbl_slot #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_slot (
    .clk   (clk),
    .load  (in_take),
    .index (entry_index),
    .slot  (slot)
  );

  petbl_ram #(
    .WIDTH (TOKEN_W),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (slot),
    .wdata (count_wdata),
    .re    (rd_en),
    .raddr (slot),
    .rdata (count_rdata)
  );

  petbl_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (slot),
    .wdata (now_reg),
    .re    (rd_en),
    .raddr (slot),
    .rdata (stamp_rdata)
  );

  // Tick difference wraps modulo 2^32 by the width of the subtraction.
  assign elapsed = now_reg - stamp_rdata;

  petbl_refill #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_refill (
    .clk     (clk),
    .elapsed (elapsed),
    .rate    (refill_per_second),
    .refill  (refill)
  );

  // Refill saturates at the capacity. When no whole token was earned, the bucket
  // keeps its count untouched, even if it sits above a lowered capacity.
  assign sum = {1'b0, count_rdata} + {1'b0, refill.quotient};

  always_comb begin
    if (refill.big || (sum > {1'b0, bucket_capacity})) begin
      capped = bucket_capacity;
    end else begin
      capped = sum[TOKEN_W-1:0];
    end
  end

  assign tokens      = refill.nonzero ? capped : count_rdata;
  assign has_token   = (tokens != '0);
  assign tokens_left = has_token ? (tokens - 1'b1) : '0;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (func_reg == FUNC_INIT) begin
          if (out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    count_we    = 1'b0;
    stamp_we    = 1'b0;
    count_wdata = tokens_left;
    out_load    = 1'b0;
    result      = has_token;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_ADDR: begin
        if (func_reg == FUNC_INIT) begin
          count_wdata = bucket_capacity;
          count_we    = out_free;
          stamp_we    = out_free;
          out_load    = out_free;
          result      = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_UPD: begin
        count_we = out_free;
        stamp_we = out_free && refill.nonzero;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Output register: holds one finished result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accept <= result;
    end
  end

  // A new result only comes from the last state of a request.
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ST_UPD) || (state == ST_ADDR && func_reg == FUNC_INIT))
    else $error("result loaded outside a finishing state");

  // A stamp is never moved without the matching count write.
  assert property (@(posedge clk) disable iff (rst)
    stamp_we |-> count_we)
    else $error("stamp written without a count write");

  // A check request walks read, multiply and update in fixed order.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR && func_reg == FUNC_CHECK)
      |=> (state == ST_READ) ##1 (state == ST_MUL) ##1 (state == ST_UPD))
    else $error("check request left the read-modify-write sequence");

  // An accepted request starts the sequencer and closes the input.
  assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_ADDR) && in_stall)
    else $error("accepted request did not start the sequencer");

  // A waiting result is never overwritten by the next one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && out_valid && out_stall) |=> (state == ST_UPD) && !$past(count_we))
    else $error("update finished while the output register was full");

endmodule
